[hdl/pihbb_pkg.sv]
`default_nettype none
package pihbb_pkg;

  // Coordinate precision: words carry 32 bits, and only the low
  // min(COORD_W, 32) bits are significant (sign-extended from there).
  localparam int COORD_W  = 32;
  localparam int COORD_SB = (COORD_W < 32) ? COORD_W : 32;
  localparam int COORD_EX = 32 - COORD_SB;

  // APB register map: register i at byte address 4*i.
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_QUERY_X     = 3'd0,
    REG_QUERY_Y     = 3'd1,
    REG_RECT_LEFT   = 3'd2,
    REG_RECT_BOTTOM = 3'd3,
    REG_RECT_RIGHT  = 3'd4,
    REG_RECT_TOP    = 3'd5,
    REG_CLOSE_RING  = 3'd6
  } cfg_reg_e;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [65:0] prod_t;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t rect_left;
    coord_t rect_bottom;
    coord_t rect_right;
    coord_t rect_top;
    logic   close_ring;
  } cfg_t;

  // Operands of one edge crossing test: a*b against c*d.
  typedef struct packed {
    logic  en;    // edge straddles the ray line and takes part
    logic  dpos;  // edge runs upward (d > 0)
    diff_t a;     // qy - y1
    diff_t b;     // x2 - x1
    diff_t c;     // qx - x1
    diff_t d;     // y2 - y1
  } seg_op_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  typedef struct packed {
    logic    last;
    box_t    box;
    seg_op_t open_seg;   // previous vertex to this one
    seg_op_t close_seg;  // this vertex back to the first
  } a_stage_t;

  function automatic coord_t to_coord(logic [31:0] raw);
    coord_t t;
    t = coord_t'(raw << COORD_EX);
    return t >>> COORD_EX;
  endfunction

  function automatic diff_t sub_c(coord_t p, coord_t q);
    return diff_t'({p[31], p}) - diff_t'({q[31], q});
  endfunction

endpackage
`default_nettype wire

[hdl/polygon_hit_and_bbox_test_top.sv]
`default_nettype none
// Polygon pick and bounding-box test. Vertices of a polyline stream in as
// signed Q16.16 words, one per unstalled cycle, the final one flagged by last_vertex_i.
// For each edge the block runs the even-odd crossing test of a ray from the
// pick point (query_x, query_y) toward +x, using an exact cross-multiplied
// compare instead of a division, and tracks the bounding box of all
// vertices. With close_ring set, the edge from the final vertex back to the
// first is tested too. The final vertex yields one result word: hit (odd
// crossing count), in_rect (box lies fully inside the selection rectangle,
// 0 when the rectangle is inverted) and the box; other vertices yield
// nothing, and the polyline state clears after the final vertex.
// Rate: one vertex per cycle while vertex_stall_o is low; a final vertex
// held by a stalled result raises it. Between a final vertex and its result
// lie three register stages: operand forming at the input, four 33x33
// multipliers (two per edge test), then compare and parity into the output
// register. Only a final vertex waits on a stalled result; ordinary vertices
// keep flowing.
// Config (APB, pready tied high, byte address 4*i): 0 query_x, 1 query_y,
// 2 rect_left, 3 rect_bottom, 4 rect_right, 5 rect_top, 6 close_ring
// (reset 1, others reset 0). Write only while the block is idle.
module polygon_hit_and_bbox_test_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // APB config port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pihbb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // vertex input channel
  input  wire logic                         vertex_valid_i,
  output logic                              vertex_stall_o,
  input  wire logic signed [31:0]           vertex_x_i,
  input  wire logic signed [31:0]           vertex_y_i,
  input  wire logic                         last_vertex_i,
  // result channel
  output logic                              result_valid_o,
  input  wire logic                         result_stall_i,
  output logic                              hit_o,
  output logic                              in_rect_o,
  output logic signed [31:0]                box_min_x_o,
  output logic signed [31:0]                box_min_y_o,
  output logic signed [31:0]                box_max_x_o,
  output logic signed [31:0]                box_max_y_o
);
  import pihbb_pkg::*;

  cfg_t     cfg;
  a_stage_t a_stage;

  logic fire_in, a_go, b_go;
  logic va_q, vb_q;
  logic cross_open, cross_close;

  // stage B side payload
  logic b_last_q;
  logic b_in_rect_q;
  box_t b_box_q;
  logic in_rect_d;

  logic parity_q;

  // output register
  logic out_valid_q;
  logic hit_q, in_rect_q;
  box_t out_box_q;

  pihbb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pihbb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire_in),
    .cfg_i         (cfg),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .stage_o       (a_stage)
  );

  pihbb_seg u_seg_open (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (a_go),
    .op_i    (a_stage.open_seg),
    .cross_o (cross_open)
  );

  pihbb_seg u_seg_close (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (a_go),
    .op_i    (a_stage.close_seg),
    .cross_o (cross_close)
  );

  // Stage B only blocks when it holds a final word and the output register
  // still holds an untaken result; everything upstream advances into holes.
  assign b_go           = vb_q && (!b_last_q || !out_valid_q || !result_stall_i);
  assign a_go           = va_q && (!vb_q || b_go);
  assign vertex_stall_o = va_q && !a_go;
  assign fire_in        = vertex_valid_i && !vertex_stall_o;

  assign in_rect_d = (a_stage.box.min_x >= cfg.rect_left)   &&
                     (a_stage.box.min_y >= cfg.rect_bottom) &&
                     (a_stage.box.max_x <= cfg.rect_right)  &&
                     (a_stage.box.max_y <= cfg.rect_top);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (fire_in) begin
        va_q <= 1'b1;
      end else if (a_go) begin
        va_q <= 1'b0;
      end
      if (a_go) begin
        vb_q <= 1'b1;
      end else if (b_go) begin
        vb_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_last_q    <= a_stage.last;
      b_box_q     <= a_stage.box;
      b_in_rect_q <= in_rect_d;
    end
  end

  // Accumulate crossings; clear once the final word leaves stage B.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
    end else if (b_go) begin
      parity_q <= b_last_q ? 1'b0 : (parity_q ^ cross_open);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_go && b_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!result_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go && b_last_q) begin
      hit_q     <= parity_q ^ cross_open ^ cross_close;
      in_rect_q <= b_in_rect_q;
      out_box_q <= b_box_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign hit_o          = hit_q;
  assign in_rect_o      = in_rect_q;
  assign box_min_x_o    = out_box_q.min_x;
  assign box_min_y_o    = out_box_q.min_y;
  assign box_max_x_o    = out_box_q.max_x;
  assign box_max_y_o    = out_box_q.max_y;

endmodule
`default_nettype wire

[hdl/pihbb_cfg.sv]
`default_nettype none
module pihbb_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pihbb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output pihbb_pkg::cfg_t                  cfg_o
);
  import pihbb_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e idx;
  logic     wr_en;

  assign idx    = cfg_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_QUERY_X:     cfg_d.query_x     = to_coord(pwdata);
        REG_QUERY_Y:     cfg_d.query_y     = to_coord(pwdata);
        REG_RECT_LEFT:   cfg_d.rect_left   = to_coord(pwdata);
        REG_RECT_BOTTOM: cfg_d.rect_bottom = to_coord(pwdata);
        REG_RECT_RIGHT:  cfg_d.rect_right  = to_coord(pwdata);
        REG_RECT_TOP:    cfg_d.rect_top    = to_coord(pwdata);
        REG_CLOSE_RING:  cfg_d.close_ring  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_QUERY_X:     prdata = cfg_q.query_x;
      REG_QUERY_Y:     prdata = cfg_q.query_y;
      REG_RECT_LEFT:   prdata = cfg_q.rect_left;
      REG_RECT_BOTTOM: prdata = cfg_q.rect_bottom;
      REG_RECT_RIGHT:  prdata = cfg_q.rect_right;
      REG_RECT_TOP:    prdata = cfg_q.rect_top;
      REG_CLOSE_RING:  prdata = {31'b0, cfg_q.close_ring};
      default:         prdata = '0;
    endcase
  end

  // everything resets to zero except close_ring, the lowest bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_t'({192'b0, 1'b1});
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

[hdl/pihbb_front.sv]
`default_nettype none
module pihbb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire pihbb_pkg::cfg_t   cfg_i,
  input  wire logic [31:0]       vertex_x_i,
  input  wire logic [31:0]       vertex_y_i,
  input  wire logic              last_vertex_i,
  output pihbb_pkg::a_stage_t    stage_o
);
  import pihbb_pkg::*;

  coord_t   x, y, fx, fy;
  coord_t   prev_x_q, prev_y_q, first_x_q, first_y_q;
  box_t     box_q, box_d;
  logic     have_q;
  a_stage_t stage_q, stage_d;

  assign x  = to_coord(vertex_x_i);
  assign y  = to_coord(vertex_y_i);
  // a lone vertex closes onto itself
  assign fx = have_q ? first_x_q : x;
  assign fy = have_q ? first_y_q : y;

  always_comb begin
    box_d.min_x = (!have_q || x < box_q.min_x) ? x : box_q.min_x;
    box_d.min_y = (!have_q || y < box_q.min_y) ? y : box_q.min_y;
    box_d.max_x = (!have_q || x > box_q.max_x) ? x : box_q.max_x;
    box_d.max_y = (!have_q || y > box_q.max_y) ? y : box_q.max_y;

    stage_d.last = last_vertex_i;
    stage_d.box  = box_d;

    stage_d.open_seg.en   = have_q && ((prev_y_q > cfg_i.query_y) != (y > cfg_i.query_y));
    stage_d.open_seg.dpos = y > cfg_i.query_y;
    stage_d.open_seg.a    = sub_c(cfg_i.query_y, prev_y_q);
    stage_d.open_seg.b    = sub_c(x, prev_x_q);
    stage_d.open_seg.c    = sub_c(cfg_i.query_x, prev_x_q);
    stage_d.open_seg.d    = sub_c(y, prev_y_q);

    stage_d.close_seg.en   = cfg_i.close_ring &&
                             ((y > cfg_i.query_y) != (fy > cfg_i.query_y));
    stage_d.close_seg.dpos = fy > cfg_i.query_y;
    stage_d.close_seg.a    = sub_c(cfg_i.query_y, y);
    stage_d.close_seg.b    = sub_c(fx, x);
    stage_d.close_seg.c    = sub_c(cfg_i.query_x, x);
    stage_d.close_seg.d    = sub_c(fy, y);
  end

  assign stage_o = stage_q;

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      stage_q <= stage_d;
    end
  end

  // polyline state; drop it all after the final vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      box_q     <= '0;
    end else if (fire_i) begin
      if (last_vertex_i) begin
        have_q    <= 1'b0;
        prev_x_q  <= '0;
        prev_y_q  <= '0;
        first_x_q <= '0;
        first_y_q <= '0;
        box_q     <= '0;
      end else begin
        have_q    <= 1'b1;
        prev_x_q  <= x;
        prev_y_q  <= y;
        first_x_q <= fx;
        first_y_q <= fy;
        box_q     <= box_d;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/pihbb_seg.sv]
`default_nettype none
module pihbb_seg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire pihbb_pkg::seg_op_t  op_i,
  output logic                     cross_o
);
  import pihbb_pkg::*;

  prod_t p1_q, p2_q;
  logic  en_q, dpos_q;

  // exact products; the compare follows one register later
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p1_q   <= prod_t'(op_i.a) * prod_t'(op_i.b);
      p2_q   <= prod_t'(op_i.c) * prod_t'(op_i.d);
      dpos_q <= op_i.dpos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (load_i) begin
      en_q <= op_i.en;
    end
  end

  assign cross_o = en_q && (dpos_q ? (p1_q > p2_q) : (p1_q < p2_q));

endmodule
`default_nettype wire
